// File: hdl/socks5_connect_request_parser_macros.svh
// ----------------------------------------------------------------------------
// SOCKS5 request parser assertion macros
// Short forms for the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOCKS5_CONNECT_REQUEST_PARSER_MACROS_SVH
`define SOCKS5_CONNECT_REQUEST_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define S5CR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("s5cr: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define S5CR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("s5cr: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define S5CR_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
   else $error("s5cr: reset-time check failed");

`endif

// File: hdl/s5cr_pkg.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser package
// Phase and event codes, protocol constants and the request and response
// payload types shared by the parser modules.
// ----------------------------------------------------------------------------
package s5cr_pkg;

   typedef enum logic [3:0] {
      PH_GREET_VER = 4'd0,
      PH_GREET_CNT = 4'd1,
      PH_METHODS   = 4'd2,
      PH_REQ_VER   = 4'd3,
      PH_REQ_CMD   = 4'd4,
      PH_REQ_RSV   = 4'd5,
      PH_REQ_ATYP  = 4'd6,
      PH_DOM_LEN   = 4'd7,
      PH_ADDR      = 4'd8,
      PH_PORT_HI   = 4'd9,
      PH_PORT_LO   = 4'd10,
      PH_DONE      = 4'd11
   } phase_type;

   typedef enum logic [3:0] {
      EV_CONSUMED  = 4'd0,
      EV_METHOD_OK = 4'd1,
      EV_NO_METHOD = 4'd2,
      EV_DONE      = 4'd3,
      EV_PROTO_ERR = 4'd4,
      EV_BAD_CMD   = 4'd5,
      EV_BAD_ATYP  = 4'd6,
      EV_PORT_ZERO = 4'd7,
      EV_IGNORED   = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      KIND_IPV4   = 2'd0,
      KIND_DOMAIN = 2'd1,
      KIND_IPV6   = 2'd2
   } addr_kind_type;

   localparam logic [7:0] SOCKS_VERSION  = 8'h05;
   localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
   localparam logic [7:0] METHOD_NONE    = 8'hFF;
   localparam logic [7:0] CMD_CONNECT    = 8'h01;
   localparam logic [7:0] RESERVED_BYTE  = 8'h00;
   localparam logic [7:0] ATYP_IPV4      = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
   localparam logic [7:0] ATYP_IPV6      = 8'h04;
   localparam logic [7:0] REP_GENERAL    = 8'h01;
   localparam logic [7:0] REP_BAD_CMD    = 8'h07;
   localparam logic [7:0] REP_BAD_ATYP   = 8'h08;
   localparam logic [7:0] IPV4_LEN       = 8'd4;
   localparam logic [7:0] IPV6_LEN       = 8'd16;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_session;
      logic       peer_closed;
   } req_type;

   typedef struct packed {
      event_type     event_res;
      logic [7:0]    reply_code;
      logic          target_valid;
      logic [7:0]    target_byte;
      addr_kind_type address_type;
      logic [15:0]   target_port;
   } rsp_type;

endpackage

// File: hdl/s5cr_if.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser channels
// Valid/ready channels for client bytes in and parse results out.
// ----------------------------------------------------------------------------
interface s5cr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_session;
   logic       peer_closed;

   modport source (output valid, output data_byte, output new_session,
                   output peer_closed, input ready);
   modport sink (input valid, input data_byte, input new_session,
                 input peer_closed, output ready);
endinterface

interface s5cr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  event_res;
   logic [7:0]  reply_code;
   logic        target_valid;
   logic [7:0]  target_byte;
   logic [1:0]  address_type;
   logic [15:0] target_port;

   modport source (output valid, output event_res, output reply_code,
                   output target_valid, output target_byte, output address_type,
                   output target_port, input ready);
   modport sink (input valid, input event_res, input reply_code,
                 input target_valid, input target_byte, input address_type,
                 input target_port, output ready);
endinterface

// File: hdl/s5cr_in_stage.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser input register
// Captures one client byte per cycle while it is empty or its byte moves on,
// and holds it until the parser advances.
module s5cr_in_stage
   import s5cr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   s5cr_req_if.sink    req_if,
   input  logic        advance,
   output logic        item_valid,
   output req_type     item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   // The register can take a new byte when empty or when its byte moves on.
   assign req_if.ready = !valid_ff || advance;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_if.ready) begin
         valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte   <= req_if.data_byte;
         item_ff.new_session <= req_if.new_session;
         item_ff.peer_closed <= req_if.peer_closed;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hdl/s5cr_core.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser phase machine
// Holds the handshake state and works out the result of one client byte.
// ----------------------------------------------------------------------------
module s5cr_core
   import s5cr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   phase_type     phase_ff,        phase_in;
   logic [7:0]    bytes_left_ff,   bytes_left_in;
   logic          no_auth_ff,      no_auth_in;
   logic          header_bad_ff,   header_bad_in;
   logic          command_bad_ff,  command_bad_in;
   addr_kind_type kind_ff,         kind_in;
   logic          zero_dom_ff,     zero_dom_in;
   logic [7:0]    port_high_ff,    port_high_in;

   // State as seen by this byte: a new session starts from the reset values.
   phase_type     cur_phase;
   logic [7:0]    cur_bytes_left;
   logic          cur_no_auth;
   logic          cur_header_bad;
   logic          cur_command_bad;
   addr_kind_type cur_kind;
   logic          cur_zero_dom;
   logic [7:0]    cur_port_high;

   always_comb begin
      if (item.new_session) begin
         cur_phase       = PH_GREET_VER;
         cur_bytes_left  = 8'd0;
         cur_no_auth     = 1'b0;
         cur_header_bad  = 1'b0;
         cur_command_bad = 1'b0;
         cur_kind        = KIND_IPV4;
         cur_zero_dom    = 1'b0;
         cur_port_high   = 8'd0;
      end else begin
         cur_phase       = phase_ff;
         cur_bytes_left  = bytes_left_ff;
         cur_no_auth     = no_auth_ff;
         cur_header_bad  = header_bad_ff;
         cur_command_bad = command_bad_ff;
         cur_kind        = kind_ff;
         cur_zero_dom    = zero_dom_ff;
         cur_port_high   = port_high_ff;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  count_dec;
      logic        no_auth_now;
      logic        zero_now;
      logic [15:0] port_word;
      event_type   ev;
      logic [7:0]  reply;
      logic        tvalid;
      logic [7:0]  tbyte;

      b           = item.data_byte;
      count_dec   = cur_bytes_left - 8'd1;
      no_auth_now = cur_no_auth || (b == METHOD_NO_AUTH);
      zero_now    = cur_zero_dom || ((cur_kind == KIND_DOMAIN) && (b == 8'd0));
      port_word   = {cur_port_high, b};
      ev          = EV_CONSUMED;
      reply       = 8'd0;
      tvalid      = 1'b0;
      tbyte       = 8'd0;

      phase_in       = cur_phase;
      bytes_left_in  = cur_bytes_left;
      no_auth_in     = cur_no_auth;
      header_bad_in  = cur_header_bad;
      command_bad_in = cur_command_bad;
      kind_in        = cur_kind;
      zero_dom_in    = cur_zero_dom;
      port_high_in   = cur_port_high;

      if (cur_phase >= PH_DONE) begin
         ev = EV_IGNORED;
      end else if (item.peer_closed) begin
         ev       = EV_PROTO_ERR;
         phase_in = PH_DONE;
      end else begin
         unique case (cur_phase)
            PH_GREET_VER: begin
               header_bad_in = (b != SOCKS_VERSION);
               phase_in      = PH_GREET_CNT;
            end
            PH_GREET_CNT: begin
               if (cur_header_bad || (b == 8'd0)) begin
                  ev       = EV_PROTO_ERR;
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = b;
                  no_auth_in    = 1'b0;
                  phase_in      = PH_METHODS;
               end
            end
            PH_METHODS: begin
               no_auth_in    = no_auth_now;
               bytes_left_in = count_dec;
               if (count_dec == 8'd0) begin
                  if (no_auth_now) begin
                     ev       = EV_METHOD_OK;
                     reply    = METHOD_NO_AUTH;
                     phase_in = PH_REQ_VER;
                  end else begin
                     ev       = EV_NO_METHOD;
                     reply    = METHOD_NONE;
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_REQ_VER: begin
               header_bad_in = (b != SOCKS_VERSION);
               phase_in      = PH_REQ_CMD;
            end
            PH_REQ_CMD: begin
               command_bad_in = (b != CMD_CONNECT);
               phase_in       = PH_REQ_RSV;
            end
            PH_REQ_RSV: begin
               header_bad_in = cur_header_bad || (b != RESERVED_BYTE);
               phase_in      = PH_REQ_ATYP;
            end
            PH_REQ_ATYP: begin
               // Header faults outrank a bad command, which outranks the type.
               if (cur_header_bad) begin
                  ev       = EV_PROTO_ERR;
                  phase_in = PH_DONE;
               end else if (cur_command_bad) begin
                  ev       = EV_BAD_CMD;
                  reply    = REP_BAD_CMD;
                  phase_in = PH_DONE;
               end else if (b == ATYP_IPV4) begin
                  kind_in       = KIND_IPV4;
                  bytes_left_in = IPV4_LEN;
                  zero_dom_in   = 1'b0;
                  phase_in      = PH_ADDR;
               end else if (b == ATYP_IPV6) begin
                  kind_in       = KIND_IPV6;
                  bytes_left_in = IPV6_LEN;
                  zero_dom_in   = 1'b0;
                  phase_in      = PH_ADDR;
               end else if (b == ATYP_DOMAIN) begin
                  kind_in  = KIND_DOMAIN;
                  phase_in = PH_DOM_LEN;
               end else begin
                  ev       = EV_BAD_ATYP;
                  reply    = REP_BAD_ATYP;
                  phase_in = PH_DONE;
               end
            end
            PH_DOM_LEN: begin
               if (b == 8'd0) begin
                  ev       = EV_PROTO_ERR;
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = b;
                  zero_dom_in   = 1'b0;
                  phase_in      = PH_ADDR;
               end
            end
            PH_ADDR: begin
               tvalid        = 1'b1;
               tbyte         = b;
               zero_dom_in   = zero_now;
               bytes_left_in = count_dec;
               if (count_dec == 8'd0) begin
                  if (zero_now) begin
                     ev       = EV_PROTO_ERR;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_PORT_HI;
                  end
               end
            end
            PH_PORT_HI: begin
               port_high_in = b;
               phase_in     = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               if (port_word == 16'd0) begin
                  ev    = EV_PORT_ZERO;
                  reply = REP_GENERAL;
               end else begin
                  ev = EV_DONE;
               end
               phase_in = PH_DONE;
            end
            default: begin
               ev = EV_IGNORED;
            end
         endcase
      end

      result.event_res    = ev;
      result.reply_code   = reply;
      result.target_valid = tvalid;
      result.target_byte  = tbyte;
      result.address_type = kind_in;
      result.target_port  = (ev == EV_DONE) ? port_word : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_GREET_VER;
         bytes_left_ff  <= 8'd0;
         no_auth_ff     <= 1'b0;
         header_bad_ff  <= 1'b0;
         command_bad_ff <= 1'b0;
         kind_ff        <= KIND_IPV4;
         zero_dom_ff    <= 1'b0;
         port_high_ff   <= 8'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         no_auth_ff     <= no_auth_in;
         header_bad_ff  <= header_bad_in;
         command_bad_ff <= command_bad_in;
         kind_ff        <= kind_in;
         zero_dom_ff    <= zero_dom_in;
         port_high_ff   <= port_high_in;
      end
   end

endmodule

// File: hdl/s5cr_out_stage.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser result register
// Holds one parse result until the consumer takes it and decides when the
// parser may advance.
// ----------------------------------------------------------------------------
module s5cr_out_stage
   import s5cr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  rsp_type     result,
   output logic        advance,
   s5cr_rsp_if.source  rsp_if
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;

   // A byte moves on when the result register is empty or being drained.
   assign advance = item_valid && (!valid_ff || rsp_if.ready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.event_res    = result_ff.event_res;
   assign rsp_if.reply_code   = result_ff.reply_code;
   assign rsp_if.target_valid = result_ff.target_valid;
   assign rsp_if.target_byte  = result_ff.target_byte;
   assign rsp_if.address_type = result_ff.address_type;
   assign rsp_if.target_port  = result_ff.target_port;

endmodule

// File: hdl/socks5_connect_request_parser.sv
// ----------------------------------------------------------------------------
// SOCKS5 connect request parser
// Server-side SOCKS5 handshake parser that consumes one client byte per
// request and returns one parse result per byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   req_if    in         valid/ready    data_byte, new_session, peer_closed
//   rsp_if    out        valid/ready    event_res, reply_code, target_valid,
//                                       target_byte, address_type, target_port
//
// One request is taken every cycle while results are being drained. Each
// request is loaded into the input register when it is accepted, and its
// result into the result register when the byte moves on; the result is shown
// from there. The phase registers close a loop through the phase machine,
// which sets the rate at one byte per cycle while the result register can
// take it. Reset is synchronous and returns the parser to the greeting
// version byte with both registers empty. When the result register is held
// by a stalled consumer, the byte in the input register waits, and
// req_if.ready drops once that register is also full.
//
// The parser walks the greeting, the method list, the four request header
// bytes, the target address (IPv4, IPv6 or domain) and the two port bytes.
// Target bytes are forwarded as they arrive. A final event (no acceptable
// method, request done, or any failure) parks the parser until a request
// with new_session set, which restarts it before that byte is looked at.
// ----------------------------------------------------------------------------
module socks5_connect_request_parser
   import s5cr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   s5cr_req_if.sink    req_if,
   s5cr_rsp_if.source  rsp_if
);

   logic    item_valid;
   req_type item;
   rsp_type result;
   logic    advance;

   // Input register: holds the next client byte.
   s5cr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Phase machine: the state update and the result for the held byte.
   // It commits its state only on a cycle in which the byte moves on.
   s5cr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   // Result register: parts the parser from a stalling consumer.
   s5cr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_if     (rsp_if)
   );

endmodule

// File: hdl/s5cr_checker.sv
// ----------------------------------------------------------------------------
// SOCKS5 request parser port checker
// Concurrent checks on what the parser shows at its ports over time.
// ----------------------------------------------------------------------------
`include "socks5_connect_request_parser_macros.svh"

module s5cr_checker
   import s5cr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  event_res,
   input logic [7:0]  reply_code,
   input logic        target_valid,
   input logic [15:0] target_port
);

   logic [31:0] rsp_word;

   assign rsp_word = {event_res, reply_code, target_valid, target_port[15:0], 3'd0};

   // No result may be shown in the cycle after reset.
   `S5CR_ASSERT_ALWAYS_NXT(a_empty_after_reset, clock, reset, !rsp_valid)

   // A stalled result stays and keeps its event, reply code, target flag and port.
   `S5CR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // A reply code other than zero comes only with the events that carry one.
   `S5CR_ASSERT_IMP(a_reply_event, clock, reset, rsp_valid && (reply_code != 8'd0), (event_res == EV_NO_METHOD) || (event_res == EV_BAD_CMD) || (event_res == EV_BAD_ATYP) || (event_res == EV_PORT_ZERO))

   // Forwarded target bytes never arrive with a success or selection event.
   `S5CR_ASSERT_IMP(a_target_event, clock, reset, rsp_valid && target_valid, (event_res == EV_CONSUMED) || (event_res == EV_PROTO_ERR))

endmodule

bind socks5_connect_request_parser s5cr_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .event_res    (rsp_if.event_res),
   .reply_code   (rsp_if.reply_code),
   .target_valid (rsp_if.target_valid),
   .target_port  (rsp_if.target_port)
);
